// ----- hdl/bsaf_pkg.sv -----
// Shared types and constants for the barrel shifter ALU with NZCV flags.
package bsaf_pkg;

    typedef enum logic [3:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_SUB = 4'd2,
        OP_RSB = 4'd3,
        OP_ADD = 4'd4,
        OP_ADC = 4'd5,
        OP_SBC = 4'd6,
        OP_RSC = 4'd7,
        OP_TST = 4'd8,
        OP_TEQ = 4'd9,
        OP_CMP = 4'd10,
        OP_CMN = 4'd11,
        OP_ORR = 4'd12,
        OP_MOV = 4'd13,
        OP_BIC = 4'd14,
        OP_MVN = 4'd15
    } alu_op_t;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } shift_t;

    // Operand-two controls handed from the input stage to the shifter
    typedef struct packed {
        logic       imm_form;
        logic [7:0] imm8;
        logic [3:0] rotate_half;
        shift_t     shift_type;
        logic       shift_by_reg;
        logic [4:0] shift_amount;
        logic [7:0] rs_low_byte;
    } shift_ctl_t;

    // Bit positions inside the NZCV nibble
    localparam int unsigned FLAG_N = 3;
    localparam int unsigned FLAG_Z = 2;
    localparam int unsigned FLAG_C = 1;
    localparam int unsigned FLAG_V = 0;

endpackage

// ----- hdl/bsaf_shifter.sv -----
// Operand-two barrel shifter: rotated immediate or shifted Rm, with carry-out.
module bsaf_shifter
(
    input  bsaf_pkg::shift_ctl_t ctl,
    input  logic [31:0]          rm_value,
    input  logic                 carry_in,
    output logic [31:0]          operand,
    output logic                 carry_out
);

    function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] w;
        w = {v, v} >> n;
        return w[31:0];
    endfunction

    logic [4:0]  rot_amt;
    logic [31:0] imm_rot;
    logic [5:0]  amt6;
    logic        pass;
    logic        zero_out;
    logic [32:0] lsl_w;
    logic [32:0] lsr_w;
    logic [32:0] asr_w;
    logic [31:0] ror_w;
    logic [31:0] rrx_w;

    assign rot_amt = {ctl.rotate_half, 1'b0};
    assign imm_rot = ror32({24'd0, ctl.imm8}, rot_amt);

    // Resolve the special amounts into a 6-bit amount in 0..32 plus pass/zero cases
    always_comb
    begin
        amt6     = {1'b0, ctl.shift_amount};
        pass     = 1'b0;
        zero_out = 1'b0;
        if (ctl.shift_by_reg)
        begin
            if (ctl.rs_low_byte == 8'd0)
            begin
                pass = 1'b1;
            end
            else if (ctl.rs_low_byte > 8'd32)
            begin
                // ROR keeps only the low five bits of a large amount
                amt6     = (ctl.shift_type == bsaf_pkg::SH_ROR) ?
                           {1'b0, ctl.rs_low_byte[4:0]} : 6'd32;
                zero_out = (ctl.shift_type == bsaf_pkg::SH_LSL) ||
                           (ctl.shift_type == bsaf_pkg::SH_LSR);
            end
            else
            begin
                amt6 = ctl.rs_low_byte[5:0];
            end
        end
        else if (ctl.shift_amount == 5'd0)
        begin
            // immediate zero: LSL passes, LSR/ASR mean 32, ROR means RRX
            amt6 = 6'd32;
            pass = (ctl.shift_type == bsaf_pkg::SH_LSL);
        end
    end

    assign lsl_w = {1'b0, rm_value} << amt6;
    assign lsr_w = {rm_value, 1'b0} >> amt6;
    assign asr_w = $unsigned($signed({rm_value, 1'b0}) >>> amt6);
    assign ror_w = ror32(rm_value, amt6[4:0]);
    assign rrx_w = {carry_in, rm_value[31:1]};

    always_comb
    begin
        operand   = rm_value;
        carry_out = carry_in;
        if (ctl.imm_form)
        begin
            operand   = imm_rot;
            carry_out = (rot_amt == 5'd0) ? carry_in : imm_rot[31];
        end
        else if (pass)
        begin
            operand   = rm_value;
            carry_out = carry_in;
        end
        else if (zero_out)
        begin
            operand   = 32'd0;
            carry_out = 1'b0;
        end
        else
        begin
            case (ctl.shift_type)
                bsaf_pkg::SH_LSL:
                begin
                    operand   = lsl_w[31:0];
                    carry_out = lsl_w[32];
                end
                bsaf_pkg::SH_LSR:
                begin
                    operand   = lsr_w[32:1];
                    carry_out = lsr_w[0];
                end
                bsaf_pkg::SH_ASR:
                begin
                    operand   = asr_w[32:1];
                    carry_out = asr_w[0];
                end
                bsaf_pkg::SH_ROR:
                begin
                    if (!ctl.shift_by_reg && (ctl.shift_amount == 5'd0))
                    begin
                        operand   = rrx_w;
                        carry_out = rm_value[0];
                    end
                    else
                    begin
                        operand   = ror_w;
                        carry_out = ror_w[31];
                    end
                end
                default:
                begin
                    operand   = rm_value;
                    carry_out = carry_in;
                end
            endcase
        end
    end

endmodule

// ----- hdl/barrel_shifter_alu_flags.sv -----
// Top level: input register, shifter and ALU, result register with NZCV flags.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------------
//  in      | in_valid / in_ready  | func set_flags imm_form imm8 rotate_half
//          |                      | shift_type shift_by_reg shift_amount rn_value
//          |                      | rm_value rs_low_byte flags_in
//  out     | out_valid / out_ready| alu_result write_back flags_out
//
// Two register stages: an item is captured in the input register, and the shifter and
// 33-bit adder between the two stages feed the result register. One item per cycle
// is sustained while out_ready is high; out_valid rises when the item moves into the
// result register. Reset clears only the two stage valid bits. A stall on out_ready
// holds the result register, and in_ready drops only when both stages are full.
module barrel_shifter_alu_flags
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  func,
    input  logic        set_flags,
    input  logic        imm_form,
    input  logic [7:0]  imm8,
    input  logic [3:0]  rotate_half,
    input  logic [1:0]  shift_type,
    input  logic        shift_by_reg,
    input  logic [4:0]  shift_amount,
    input  logic [31:0] rn_value,
    input  logic [31:0] rm_value,
    input  logic [7:0]  rs_low_byte,
    input  logic [3:0]  flags_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] alu_result,
    output logic        write_back,
    output logic [3:0]  flags_out
);

    logic                 s1_valid_reg;
    bsaf_pkg::alu_op_t    func_reg;
    logic                 set_flags_reg;
    bsaf_pkg::shift_ctl_t ctl_reg;
    logic [31:0]          rn_reg;
    logic [31:0]          rm_reg;
    logic [3:0]           flags_reg;

    logic                 out_valid_reg;
    logic [31:0]          result_reg;
    logic                 write_back_reg;
    logic [3:0]           flags_out_reg;

    logic                 s2_ready;
    logic                 in_fire;

    logic [31:0]          op2;
    logic                 sh_carry;
    logic [31:0]          add_a;
    logic [31:0]          add_b;
    logic                 add_c;
    logic [32:0]          sum;
    logic                 arith;
    logic                 compare;
    logic [31:0]          result_next;
    logic [3:0]           flags_next;
    logic                 carry_flag;
    logic                 ovf_flag;

    assign s2_ready = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s2_ready;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg                 <= bsaf_pkg::alu_op_t'(func);
            set_flags_reg            <= set_flags;
            ctl_reg.imm_form         <= imm_form;
            ctl_reg.imm8             <= imm8;
            ctl_reg.rotate_half      <= rotate_half;
            ctl_reg.shift_type       <= bsaf_pkg::shift_t'(shift_type);
            ctl_reg.shift_by_reg     <= shift_by_reg;
            ctl_reg.shift_amount     <= shift_amount;
            ctl_reg.rs_low_byte      <= rs_low_byte;
            rn_reg                   <= rn_value;
            rm_reg                   <= rm_value;
            flags_reg                <= flags_in;
        end
    end

    bsaf_shifter u_shifter
    (
        .ctl       (ctl_reg),
        .rm_value  (rm_reg),
        .carry_in  (flags_reg[bsaf_pkg::FLAG_C]),
        .operand   (op2),
        .carry_out (sh_carry)
    );

    // Shared adder operands: subtraction is a + ~b + carry, reverse subtraction ~a + b + carry
    always_comb
    begin
        add_a = rn_reg;
        add_b = op2;
        add_c = 1'b0;
        arith = 1'b1;
        case (func_reg)
            bsaf_pkg::OP_SUB, bsaf_pkg::OP_CMP:
            begin
                add_b = ~op2;
                add_c = 1'b1;
            end
            bsaf_pkg::OP_RSB:
            begin
                add_a = ~rn_reg;
                add_c = 1'b1;
            end
            bsaf_pkg::OP_ADD, bsaf_pkg::OP_CMN:
            begin
                add_c = 1'b0;
            end
            bsaf_pkg::OP_ADC:
            begin
                add_c = flags_reg[bsaf_pkg::FLAG_C];
            end
            bsaf_pkg::OP_SBC:
            begin
                add_b = ~op2;
                add_c = flags_reg[bsaf_pkg::FLAG_C];
            end
            bsaf_pkg::OP_RSC:
            begin
                add_a = ~rn_reg;
                add_c = flags_reg[bsaf_pkg::FLAG_C];
            end
            default:
            begin
                arith = 1'b0;
            end
        endcase
    end

    assign sum        = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_c};
    assign carry_flag = arith ? sum[32] : sh_carry;
    assign ovf_flag   = arith ? (((add_a ^ sum[31:0]) & (add_b ^ sum[31:0])) >> 31) != 32'd0
                              : flags_reg[bsaf_pkg::FLAG_V];

    assign compare = (func_reg == bsaf_pkg::OP_TST) || (func_reg == bsaf_pkg::OP_TEQ) ||
                     (func_reg == bsaf_pkg::OP_CMP) || (func_reg == bsaf_pkg::OP_CMN);

    always_comb
    begin
        case (func_reg)
            bsaf_pkg::OP_AND, bsaf_pkg::OP_TST: result_next = rn_reg & op2;
            bsaf_pkg::OP_EOR, bsaf_pkg::OP_TEQ: result_next = rn_reg ^ op2;
            bsaf_pkg::OP_ORR:                   result_next = rn_reg | op2;
            bsaf_pkg::OP_MOV:                   result_next = op2;
            bsaf_pkg::OP_BIC:                   result_next = rn_reg & ~op2;
            bsaf_pkg::OP_MVN:                   result_next = ~op2;
            default:                            result_next = sum[31:0];
        endcase
    end

    always_comb
    begin
        flags_next = flags_reg;
        if (compare || set_flags_reg)
        begin
            flags_next[bsaf_pkg::FLAG_N] = result_next[31];
            flags_next[bsaf_pkg::FLAG_Z] = (result_next == 32'd0);
            flags_next[bsaf_pkg::FLAG_C] = carry_flag;
            flags_next[bsaf_pkg::FLAG_V] = ovf_flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            result_reg     <= result_next;
            write_back_reg <= !compare;
            flags_out_reg  <= flags_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign alu_result = result_reg;
    assign write_back = write_back_reg;
    assign flags_out  = flags_out_reg;

endmodule
